FILE: rtl/core/zone_average_color_macros.svh
`ifndef ZONE_AVERAGE_COLOR_MACROS_SVH
`define ZONE_AVERAGE_COLOR_MACROS_SVH

// same-cycle implication, sampled on clk and off while arst_n is low
`define ZAC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk and off while arst_n is low
`define ZAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/zac_pkg.sv
package zac_pkg;

	localparam int MAX_LINE_PIXELS = 4096;
	localparam int MAX_FRAME_LINES = 4096;

	// pixel and result field widths
	localparam int PIX_W   = 8;
	localparam int AVG_W   = 8;
	localparam int SUM_W   = 32;
	localparam int TALLY_W = 25;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_SIZE_W = 13;
	localparam int CFG_POS_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_LEFT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_TOP   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LEFT     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_TOP      = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SPAN_X   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SPAN_Y   = CFG_IDX_W'(7);

	localparam logic [CFG_SIZE_W-1:0] SCREEN_WIDTH_RST  = CFG_SIZE_W'(1920);
	localparam logic [CFG_SIZE_W-1:0] SCREEN_HEIGHT_RST = CFG_SIZE_W'(1080);
	localparam logic [CFG_SIZE_W-1:0] ZONE_SPAN_RST     = CFG_SIZE_W'(64);

	// raster position and zone edge widths
	localparam int COL_W = $clog2(MAX_LINE_PIXELS);
	localparam int ROW_W = $clog2(MAX_FRAME_LINES);
	localparam int XW    = $clog2(MAX_LINE_PIXELS + 1);
	localparam int YW    = $clog2(MAX_FRAME_LINES + 1);
	localparam int REL_W = CFG_POS_W + 2;

	// zone width is cut down to a multiple of this
	localparam int ZONE_ALIGN = 4;
	localparam int ALIGN_BITS = $clog2(ZONE_ALIGN);

	// depth of the zone bounds pipeline
	localparam int SETUP_CYCLES = 4;
	localparam int SETUP_CNT_W  = $clog2(SETUP_CYCLES);
	localparam int BIT_W        = $clog2(AVG_W);

	typedef enum logic [2:0] {
		ST_SETUP,
		ST_RUN,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_SAVE,
		ST_PUBLISH
	} zac_state_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} zac_chan_t;

	typedef struct packed {
		logic      pix_take;
		logic      div_load;
		logic      div_step;
		logic      div_save;
		zac_chan_t chan;
		logic      publish;
	} zac_cmd_t;

	typedef struct packed {
		logic out_free;
	} zac_stat_t;

endpackage

FILE: rtl/core/zac_ifs.sv
interface zac_pix_if;
	import zac_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pix_blue;
	logic [PIX_W-1:0] pix_green;
	logic [PIX_W-1:0] pix_red;
	logic             frame_end;

	modport source (output valid, pix_blue, pix_green, pix_red, frame_end, input ready);
	modport sink (input valid, pix_blue, pix_green, pix_red, frame_end, output ready);
endinterface

interface zac_res_if;
	import zac_pkg::*;

	logic               valid;
	logic               ready;
	logic [AVG_W-1:0]   avg_red;
	logic [AVG_W-1:0]   avg_green;
	logic [AVG_W-1:0]   avg_blue;
	logic [TALLY_W-1:0] pixels_counted;

	modport source (output valid, avg_red, avg_green, avg_blue, pixels_counted, input ready);
	modport sink (input valid, avg_red, avg_green, avg_blue, pixels_counted, output ready);
endinterface

FILE: rtl/core/zac_ctrl.sv
module zac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_frame_end,
	input  logic              cfg_we,
	input  zac_pkg::zac_stat_t stat,
	output logic              in_ready,
	output zac_pkg::zac_cmd_t  cmd
);
	import zac_pkg::*;

	zac_state_t              state_q, state_d;
	logic [SETUP_CNT_W-1:0]  setup_cnt_q, setup_cnt_d;
	logic [BIT_W-1:0]        bit_q, bit_d;
	zac_chan_t               chan_q, chan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SETUP;
			setup_cnt_q <= '0;
			bit_q       <= '0;
			chan_q      <= CH_RED;
		end else begin
			state_q     <= state_d;
			setup_cnt_q <= setup_cnt_d;
			bit_q       <= bit_d;
			chan_q      <= chan_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		setup_cnt_d  = setup_cnt_q;
		bit_d        = bit_q;
		chan_d       = chan_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.chan     = chan_q;
		unique case (state_q)
			ST_SETUP: begin
				// wait for the zone bounds to settle after a register write
				if (cfg_we) begin
					setup_cnt_d = '0;
				end else if (setup_cnt_q == SETUP_CNT_W'(SETUP_CYCLES - 1)) begin
					setup_cnt_d = '0;
					state_d     = ST_RUN;
				end else begin
					setup_cnt_d = setup_cnt_q + SETUP_CNT_W'(1);
				end
			end
			ST_RUN: begin
				in_ready     = 1'b1;
				cmd.pix_take = in_valid;
				if (in_valid && in_frame_end) begin
					chan_d  = CH_RED;
					state_d = ST_DIV_LOAD;
				end else if (cfg_we) begin
					setup_cnt_d = '0;
					state_d     = ST_SETUP;
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				bit_d        = '0;
				state_d      = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				if (bit_q == BIT_W'(AVG_W - 1)) begin
					state_d = ST_DIV_SAVE;
				end else begin
					bit_d = bit_q + BIT_W'(1);
				end
			end
			ST_DIV_SAVE: begin
				cmd.div_save = 1'b1;
				if (chan_q == CH_BLUE) begin
					state_d = ST_PUBLISH;
				end else begin
					chan_d  = (chan_q == CH_RED) ? CH_GREEN : CH_BLUE;
					state_d = ST_DIV_LOAD;
				end
			end
			ST_PUBLISH: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					setup_cnt_d = '0;
					state_d     = ST_SETUP;
				end
			end
			default: begin
				state_d = ST_SETUP;
			end
		endcase
	end

endmodule

FILE: rtl/core/zac_div.sv
module zac_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [zac_pkg::SUM_W-1:0]   sum,
	input  logic [zac_pkg::TALLY_W-1:0] cnt,
	output logic [zac_pkg::AVG_W-1:0]   quot
);
	import zac_pkg::*;

	localparam int REM_W = SUM_W + 2;
	localparam int DVS_W = TALLY_W + AVG_W;

	logic [REM_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [AVG_W-1:0] quot_q;
	logic             ge;

	// round half up: (2*sum + n) / (2*n); quotient never exceeds the mean range
	assign ge = rem_q >= REM_W'(dvs_q);

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= REM_W'({sum, 1'b0}) + REM_W'(cnt);
			dvs_q  <= {cnt, AVG_W'(0)};
			quot_q <= '0;
		end else if (step) begin
			if (ge) begin
				rem_q <= rem_q - REM_W'(dvs_q);
			end
			quot_q <= {quot_q[AVG_W-2:0], ge};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign quot = quot_q;

endmodule

FILE: rtl/core/zac_datapath.sv
module zac_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  zac_pkg::zac_cmd_t              cmd,
	output zac_pkg::zac_stat_t             stat,
	input  logic                           cfg_we,
	input  logic [zac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [zac_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [zac_pkg::PIX_W-1:0]      pix_blue,
	input  logic [zac_pkg::PIX_W-1:0]      pix_green,
	input  logic [zac_pkg::PIX_W-1:0]      pix_red,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [zac_pkg::AVG_W-1:0]      avg_red,
	output logic [zac_pkg::AVG_W-1:0]      avg_green,
	output logic [zac_pkg::AVG_W-1:0]      avg_blue,
	output logic [zac_pkg::TALLY_W-1:0]    pixels_counted
);
	import zac_pkg::*;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	// configuration registers
	logic [CFG_SIZE_W-1:0]       screen_width_q, screen_height_q;
	logic signed [CFG_POS_W-1:0] monitor_left_q, monitor_top_q;
	logic signed [CFG_POS_W-1:0] zone_left_q, zone_top_q;
	logic [CFG_SIZE_W-1:0]       zone_span_x_q, zone_span_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
			monitor_left_q  <= '0;
			monitor_top_q   <= '0;
			zone_left_q     <= '0;
			zone_top_q      <= '0;
			zone_span_x_q   <= ZONE_SPAN_RST;
			zone_span_y_q   <= ZONE_SPAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[CFG_SIZE_W-1:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[CFG_SIZE_W-1:0];
				CFG_MONITOR_LEFT:  monitor_left_q  <= cfg_data;
				CFG_MONITOR_TOP:   monitor_top_q   <= cfg_data;
				CFG_ZONE_LEFT:     zone_left_q     <= cfg_data;
				CFG_ZONE_TOP:      zone_top_q      <= cfg_data;
				CFG_ZONE_SPAN_X:   zone_span_x_q   <= cfg_data[CFG_SIZE_W-1:0];
				CFG_ZONE_SPAN_Y:   zone_span_y_q   <= cfg_data[CFG_SIZE_W-1:0];
			endcase
		end
	end

	// zone bounds pipeline, runs freely from the registers
	logic [XW-1:0]           sw_s1;
	logic [YW-1:0]           sh_s1;
	logic signed [REL_W-1:0] dx_s1, dy_s1;
	logic [CFG_SIZE_W-1:0]   zw_s1, zh_s1;

	always_ff @(posedge clk) begin
		if (screen_width_q == '0) begin
			sw_s1 <= XW'(1);
		end else if (REL_W'(screen_width_q) > REL_W'(MAX_LINE_PIXELS)) begin
			sw_s1 <= XW'(MAX_LINE_PIXELS);
		end else begin
			sw_s1 <= XW'(screen_width_q);
		end
		if (screen_height_q == '0) begin
			sh_s1 <= YW'(1);
		end else if (REL_W'(screen_height_q) > REL_W'(MAX_FRAME_LINES)) begin
			sh_s1 <= YW'(MAX_FRAME_LINES);
		end else begin
			sh_s1 <= YW'(screen_height_q);
		end
		dx_s1 <= REL_W'(zone_left_q) - REL_W'(monitor_left_q);
		dy_s1 <= REL_W'(zone_top_q) - REL_W'(monitor_top_q);
		zw_s1 <= zone_span_x_q;
		zh_s1 <= zone_span_y_q;
	end

	logic signed [REL_W-1:0] sw_rel, sh_rel, ex, ey;
	logic [XW-1:0]           x0_s2, xe_s2;
	logic [YW-1:0]           y0_s2, ye_s2;
	logic                    off_x_s2, off_y_s2;

	assign sw_rel = $signed(REL_W'(sw_s1));
	assign sh_rel = $signed(REL_W'(sh_s1));
	assign ex     = dx_s1 + $signed(REL_W'(zw_s1));
	assign ey     = dy_s1 + $signed(REL_W'(zh_s1));

	// left edge clips to zero, right edge to the screen width
	always_ff @(posedge clk) begin
		off_x_s2 <= ex[REL_W-1] || (dx_s1 > sw_rel);
		off_y_s2 <= ey[REL_W-1] || (dy_s1 > sh_rel);
		x0_s2    <= dx_s1[REL_W-1] ? '0 : dx_s1[XW-1:0];
		y0_s2    <= dy_s1[REL_W-1] ? '0 : dy_s1[YW-1:0];
		xe_s2    <= (ex > sw_rel) ? sw_s1 : ex[XW-1:0];
		ye_s2    <= (ey > sh_rel) ? sh_s1 : ey[YW-1:0];
	end

	logic [XW-1:0] x0_s3, xw_s3;
	logic [YW-1:0] y0_s3, yh_s3;
	logic          off_s3;

	always_ff @(posedge clk) begin
		x0_s3  <= x0_s2;
		y0_s3  <= y0_s2;
		xw_s3  <= xe_s2 - x0_s2;
		yh_s3  <= ye_s2 - y0_s2;
		off_s3 <= off_x_s2 || off_y_s2;
	end

	logic [XW-1:0] x0_s4, xhi_s4;
	logic [YW-1:0] y0_s4, yhi_s4;
	logic          zone_ok_s4;

	always_ff @(posedge clk) begin
		x0_s4      <= x0_s3;
		y0_s4      <= y0_s3;
		xhi_s4     <= x0_s3 + {xw_s3[XW-1:ALIGN_BITS], ALIGN_BITS'(0)};
		yhi_s4     <= y0_s3 + yh_s3;
		zone_ok_s4 <= !off_s3 && (xw_s3[XW-1:ALIGN_BITS] != '0) && (yh_s3 != '0);
	end

	// raster position and zone membership
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [XW-1:0]    col_ext, col_inc;
	logic [YW-1:0]    row_ext, row_inc;
	logic             hit;

	assign col_ext = XW'(col_q);
	assign row_ext = YW'(row_q);
	assign col_inc = col_ext + XW'(1);
	assign row_inc = row_ext + YW'(1);
	assign hit     = zone_ok_s4 && (col_ext >= x0_s4) && (col_ext < xhi_s4)
		&& (row_ext >= y0_s4) && (row_ext < yhi_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.pix_take) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= sw_s1) begin
				col_q <= '0;
				row_q <= (row_inc >= sh_s1) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// saturating channel sums and pixel tally
	logic [SUM_W-1:0]   red_total_q, green_total_q, blue_total_q;
	logic [TALLY_W-1:0] pixel_tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_total_q   <= '0;
			green_total_q <= '0;
			blue_total_q  <= '0;
			pixel_tally_q <= '0;
		end else if (cmd.publish) begin
			red_total_q   <= '0;
			green_total_q <= '0;
			blue_total_q  <= '0;
			pixel_tally_q <= '0;
		end else if (cmd.pix_take && hit) begin
			red_total_q   <= sat_add(red_total_q, pix_red);
			green_total_q <= sat_add(green_total_q, pix_green);
			blue_total_q  <= sat_add(blue_total_q, pix_blue);
			if (pixel_tally_q != TALLY_MAX) begin
				pixel_tally_q <= pixel_tally_q + TALLY_W'(1);
			end
		end
	end

	// one divider shared by the three channels
	logic [SUM_W-1:0] div_sum;
	logic [AVG_W-1:0] quot;

	always_comb begin
		unique case (cmd.chan)
			CH_RED:   div_sum = red_total_q;
			CH_GREEN: div_sum = green_total_q;
			CH_BLUE:  div_sum = blue_total_q;
			default:  div_sum = '0;
		endcase
	end

	zac_div u_div (
		.clk  (clk),
		.load (cmd.div_load),
		.step (cmd.div_step),
		.sum  (div_sum),
		.cnt  (pixel_tally_q),
		.quot (quot)
	);

	logic [AVG_W-1:0] avg_red_q, avg_green_q, avg_blue_q, avg_val;

	// empty zone gives black
	assign avg_val = (pixel_tally_q == '0) ? '0 : quot;

	always_ff @(posedge clk) begin
		if (cmd.div_save) begin
			unique case (cmd.chan)
				CH_RED:   avg_red_q   <= avg_val;
				CH_GREEN: avg_green_q <= avg_val;
				CH_BLUE:  avg_blue_q  <= avg_val;
				default:  avg_blue_q  <= avg_blue_q;
			endcase
		end
	end

	// result register
	logic               out_valid_q;
	logic [AVG_W-1:0]   out_red_q, out_green_q, out_blue_q;
	logic [TALLY_W-1:0] out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_red_q   <= avg_red_q;
			out_green_q <= avg_green_q;
			out_blue_q  <= avg_blue_q;
			out_count_q <= pixel_tally_q;
		end
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign avg_red         = out_red_q;
	assign avg_green       = out_green_q;
	assign avg_blue        = out_blue_q;
	assign pixels_counted  = out_count_q;

endmodule

FILE: rtl/core/zone_average_color.sv
// Mean color of one rectangular zone of a raster frame.
// pix channel: one BGR pixel per beat in raster order, frame_end set on the
// last pixel of the frame. res channel: one beat per frame with the rounded
// mean of red, green and blue over the zone and the number of pixels summed.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the zone
// is moved by the monitor origin, clipped to the screen and its width cut to
// a multiple of 4 by a four-stage bounds pipeline.
// Throughput: one pixel per cycle inside a frame. A register write drops
// pix.ready while the bounds pipeline settles.
// After the frame_end beat, pix.ready drops and one shared shift-subtract
// divider runs load, step and save for red, green and blue in turn; the
// result beat is published once the result register is free, and pix.ready
// returns when the bounds pipeline has settled again.
// A result waiting on res.ready does not block the next frame; only the
// following frame's result waits until the register is free.
// Reset: registers take their defaults, sums and raster position clear, and
// pix.ready rises when the bounds pipeline has settled after reset.
module zone_average_color (
	input  logic                           clk,
	input  logic                           arst_n,
	zac_pix_if.sink                        pix,
	zac_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [zac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [zac_pkg::CFG_DATA_W-1:0] cfg_data
);
	import zac_pkg::*;

	zac_cmd_t           cmd;
	zac_stat_t          stat;
	logic               in_valid, in_ready, in_frame_end;
	logic               out_valid, out_ready;
	logic [AVG_W-1:0]   avg_red, avg_green, avg_blue;
	logic [TALLY_W-1:0] pixels_counted;

	assign in_valid     = pix.valid;
	assign in_frame_end = pix.frame_end;
	assign pix.ready    = in_ready;
	assign out_ready    = res.ready;

	assign res.valid          = out_valid;
	assign res.avg_red        = avg_red;
	assign res.avg_green      = avg_green;
	assign res.avg_blue       = avg_blue;
	assign res.pixels_counted = pixels_counted;

	zac_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_frame_end (in_frame_end),
		.cfg_we       (cfg_we),
		.stat         (stat),
		.in_ready     (in_ready),
		.cmd          (cmd)
	);

	zac_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pix_blue       (pix.pix_blue),
		.pix_green      (pix.pix_green),
		.pix_red        (pix.pix_red),
		.frame_end      (in_frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.avg_red        (avg_red),
		.avg_green      (avg_green),
		.avg_blue       (avg_blue),
		.pixels_counted (pixels_counted)
	);

endmodule

FILE: rtl/core/zac_checker.sv
`include "zone_average_color_macros.svh"

module zac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_frame_end,
	input logic                        cfg_we,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [zac_pkg::AVG_W-1:0]   avg_red,
	input logic [zac_pkg::AVG_W-1:0]   avg_green,
	input logic [zac_pkg::AVG_W-1:0]   avg_blue,
	input logic [zac_pkg::TALLY_W-1:0] pixels_counted
);

	// the divider owns the sums until the result is out
	`ZAC_ASSERT_NEXT(a_end_stalls_input, in_valid && in_ready && in_frame_end, !in_ready, "pixel taken during averaging")

	// bounds pipeline must refill after a register write
	`ZAC_ASSERT_NEXT(a_cfg_stalls_input, cfg_we, !in_ready, "pixel taken with stale zone bounds")

	// an empty zone reports black
	`ZAC_ASSERT_IMPLY(a_empty_is_black, out_valid && (pixels_counted == '0), (avg_red == '0) && (avg_green == '0) && (avg_blue == '0), "empty zone not black")

	`ZAC_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(avg_red) && $stable(avg_green) && $stable(avg_blue) && $stable(pixels_counted), "stalled result beat changed")

endmodule

bind zone_average_color zac_checker u_zac_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.in_frame_end   (in_frame_end),
	.cfg_we         (cfg_we),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.avg_red        (avg_red),
	.avg_green      (avg_green),
	.avg_blue       (avg_blue),
	.pixels_counted (pixels_counted)
);
